@@ sv/u16u8_pkg.sv @@
// shared types and constants for the utf-16 to utf-8 encoder
`timescale 1ns / 1ps

package u16u8_pkg;

    // code unit ranges
    localparam logic [15:0] ONE_BYTE_MAX = 16'h007F;
    localparam logic [15:0] TWO_BYTE_MAX = 16'h07FF;
    localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0]  LOW_SURR_TAG  = 6'b110111;

    // byte prefixes and the replacement byte
    localparam logic [7:0] REPLACE_BYTE = 8'h3F;
    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;

    // plane offset added to the upper bits of a surrogate pair (0x10000 >> 10)
    localparam logic [10:0] PLANE_OFFSET = 11'h040;

    // input command codes
    localparam logic CMD_UNIT = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam int JOB_BYTES   = 4;
    localparam int QUEUE_DEPTH = 2;

    // one classified item: up to four bytes, first in slot 0
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [2:0]                cnt;
        logic                      last;
        logic                      stored;
    } t_job;

endpackage

@@ sv/u16u8_front.sv @@
// front end: accepts code units, tracks surrogates and budget, builds byte jobs
`timescale 1ns / 1ps

module u16u8_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_valid,
    input  logic              i_cmd,
    input  logic [15:0]       i_unit,
    input  logic              i_queue_ready,
    output logic              o_ready,
    output logic              o_push,
    output u16u8_pkg::t_job   o_job
);

    logic        r_cap_nz;
    logic [15:0] r_budget;
    logic [15:0] r_used;
    logic        r_hp;
    logic [9:0]  r_hb;

    logic        n_hp;
    logic [9:0]  n_hb;
    logic [15:0] n_used;

    logic        accept;
    logic [15:0] left;
    logic        is_low;
    logic        is_high;
    logic [2:0][7:0] fb;
    logic [2:0]  fn;
    logic        f_hold;
    logic [10:0] cp_hi;
    logic [2:0]  raw_n;
    u16u8_pkg::t_job job;

    assign o_ready = i_queue_ready;
    assign accept  = i_valid && i_queue_ready;
    assign left    = (r_used >= r_budget) ? 16'd0 : r_budget - r_used;
    assign is_low  = (i_unit[15:10] == u16u8_pkg::LOW_SURR_TAG);
    assign is_high = (i_unit[15:10] == u16u8_pkg::HIGH_SURR_TAG);
    assign cp_hi   = {1'b0, r_hb} + u16u8_pkg::PLANE_OFFSET;

    // encoding of a unit taken on its own
    always_comb begin
        fb     = '0;
        fn     = 3'd0;
        f_hold = 1'b0;
        if (i_unit <= u16u8_pkg::ONE_BYTE_MAX) begin
            fb[0] = i_unit[7:0];
            fn    = 3'd1;
        end else if (i_unit <= u16u8_pkg::TWO_BYTE_MAX) begin
            fb[0] = {u16u8_pkg::LEAD2_TAG, i_unit[10:6]};
            fb[1] = {u16u8_pkg::CONT_TAG, i_unit[5:0]};
            fn    = 3'd2;
        end else if (is_high) begin
            f_hold = 1'b1;
        end else if (is_low) begin
            fb[0] = u16u8_pkg::REPLACE_BYTE;
            fn    = 3'd1;
        end else begin
            fb[0] = {u16u8_pkg::LEAD3_TAG, i_unit[15:12]};
            fb[1] = {u16u8_pkg::CONT_TAG, i_unit[11:6]};
            fb[2] = {u16u8_pkg::CONT_TAG, i_unit[5:0]};
            fn    = 3'd3;
        end
    end

    // job assembly, budget clipping and next state
    always_comb begin
        job    = '0;
        raw_n  = 3'd0;
        n_used = r_used;
        n_hp   = r_hp;
        n_hb   = r_hb;
        if (i_cmd == u16u8_pkg::CMD_END) begin
            job.cnt    = 3'd1;
            job.last   = 1'b1;
            job.stored = r_cap_nz;
            n_used     = 16'd0;
            n_hp       = 1'b0;
            n_hb       = 10'd0;
        end else if (left != 16'd0) begin
            job.stored = 1'b1;
            if (r_hp && is_low) begin
                job.bytes[0] = {u16u8_pkg::LEAD4_TAG, cp_hi[10:8]};
                job.bytes[1] = {u16u8_pkg::CONT_TAG, cp_hi[7:2]};
                job.bytes[2] = {u16u8_pkg::CONT_TAG, cp_hi[1:0], i_unit[9:6]};
                job.bytes[3] = {u16u8_pkg::CONT_TAG, i_unit[5:0]};
                raw_n = 3'd4;
                n_hp  = 1'b0;
            end else if (r_hp) begin
                // held high surrogate was orphaned: replace it, then retry the unit
                job.bytes[0] = u16u8_pkg::REPLACE_BYTE;
                job.bytes[1] = fb[0];
                job.bytes[2] = fb[1];
                job.bytes[3] = fb[2];
                raw_n = 3'd1;
                n_hp  = 1'b0;
                if (left > 16'd1) begin
                    raw_n = 3'd1 + fn;
                    n_hp  = f_hold;
                    n_hb  = i_unit[9:0];
                end
            end else begin
                job.bytes[0] = fb[0];
                job.bytes[1] = fb[1];
                job.bytes[2] = fb[2];
                raw_n = fn;
                n_hp  = f_hold;
                n_hb  = i_unit[9:0];
            end
            job.cnt = (left < {13'd0, raw_n}) ? left[2:0] : raw_n;
            n_used  = r_used + {13'd0, job.cnt};
        end
    end

    assign o_job  = job;
    assign o_push = accept && (job.cnt != 3'd0);

    // string state and capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_nz <= 1'b1;
            r_budget <= 16'd255;
            r_used   <= 16'd0;
            r_hp     <= 1'b0;
            r_hb     <= 10'd0;
        end else begin
            if (i_cfg_valid) begin
                r_cap_nz <= (i_cfg_data != 16'd0);
                r_budget <= (i_cfg_data == 16'd0) ? 16'd0 : i_cfg_data - 16'd1;
            end
            if (accept) begin
                r_used <= n_used;
                r_hp   <= n_hp;
                r_hb   <= n_hb;
            end
        end
    end

endmodule

@@ sv/u16u8_queue.sv @@
// two-entry job queue between front end and byte serializer
`timescale 1ns / 1ps

module u16u8_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  u16u8_pkg::t_job   i_job,
    output logic              o_ready,
    input  logic              i_pop,
    output logic              o_valid,
    output u16u8_pkg::t_job   o_job
);

    localparam int PW = $clog2(u16u8_pkg::QUEUE_DEPTH);

    u16u8_pkg::t_job r_mem [u16u8_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [PW:0]     r_cnt;

    assign o_ready = (r_cnt != (PW+1)'(u16u8_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (PW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (PW+1)'(1);
            end
        end
    end

endmodule

@@ sv/u16u8_back.sv @@
// back end: serializes queued jobs into one output byte per beat
`timescale 1ns / 1ps

module u16u8_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  u16u8_pkg::t_job   i_job,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_byte,
    output logic              o_last,
    output logic              o_stored
);

    u16u8_pkg::t_job r_job;
    logic            r_busy;
    logic [1:0]      r_idx;
    logic            r_valid;
    logic [7:0]      r_byte;
    logic            r_last;
    logic            r_stored;

    logic can_load;
    logic job_done;

    assign can_load = !r_valid || i_ready;
    assign job_done = r_busy && can_load && ({1'b0, r_idx} == r_job.cnt - 3'd1);
    assign o_pop    = i_job_valid && (!r_busy || job_done);

    assign o_valid  = r_valid;
    assign o_byte   = r_byte;
    assign o_last   = r_last;
    assign o_stored = r_stored;

    // job walker and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (can_load) begin
                r_valid <= r_busy;
                if (r_busy) begin
                    r_byte   <= r_job.bytes[r_idx];
                    r_last   <= r_job.last;
                    r_stored <= r_job.stored;
                end
            end
            if (o_pop) begin
                r_job  <= i_job;
                r_idx  <= 2'd0;
                r_busy <= 1'b1;
            end else begin
                if (job_done) begin
                    r_busy <= 1'b0;
                end
                if (can_load && r_busy) begin
                    r_idx <= r_idx + 2'd1;
                end
            end
        end
    end

endmodule

@@ sv/utf16_to_utf8_encoder.sv @@
// top level of the utf-16 to utf-8 encoder
`timescale 1ns / 1ps

// Converts a stream of UTF-16 code units (tuser 0) into UTF-8 bytes, one byte per
// output beat; an end beat (tuser 1) yields a zero terminator with tlast set and resets
// the string state. Surrogate pairs give four bytes; a lone low surrogate or a high one
// followed by a non-low unit gives '?'. Output is clipped to capacity minus one bytes
// per string. The front end takes one input beat per cycle while its two-entry job
// queue has room; the serializer sends one byte per cycle while the output is ready.
// A unit makes one byte for ASCII, two or three for other BMP characters, four per pair
// and none for a held high surrogate. The user must write the capacity register via
// the always-ready cfg channel while no string beat is in flight; it is unenforced.

module utf16_to_utf8_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,       // capacity
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // code_unit
    input  logic        i_s_axis_tuser,   // cmd
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // out_byte
    output logic        o_m_axis_tlast,
    output logic        o_m_axis_tuser    // stored
);

    logic            q_ready;
    logic            push;
    u16u8_pkg::t_job f_job;
    logic            q_valid;
    logic            pop;
    u16u8_pkg::t_job q_job;

    assign o_cfg_ready = 1'b1;

    // classify and budget
    u16u8_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_s_axis_tvalid),
        .i_cmd         (i_s_axis_tuser),
        .i_unit        (i_s_axis_tdata),
        .i_queue_ready (q_ready),
        .o_ready       (o_s_axis_tready),
        .o_push        (push),
        .o_job         (f_job)
    );

    // decoupling queue
    u16u8_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    // byte serializer
    u16u8_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_pop       (pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_byte      (o_m_axis_tdata),
        .o_last      (o_m_axis_tlast),
        .o_stored    (o_m_axis_tuser)
    );

endmodule
